// ===== rtl/row_damage_span_tracker_macros.svh =====
// assertion macros for the row damage span tracker
// needs clk and rst_n in the scope of each use
`ifndef ROW_DAMAGE_SPAN_TRACKER_MACROS_SVH
`define ROW_DAMAGE_SPAN_TRACKER_MACROS_SVH

// condition holds on every clock
`define RDST_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rdst assertion failed");

// consequence in the same cycle
`define RDST_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdst assertion failed");

// consequence in the next cycle
`define RDST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdst assertion failed");

`endif

// ===== rtl/rdst_pkg.sv =====
// shared types, constants and helpers of the row damage span tracker
// no dependencies
package rdst_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 1024;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int ROW_CNT_W = ROW_W + 1;
    localparam int COL_W     = 11;
    localparam int SPAN_W    = 2 * COL_W;
    localparam int CMD_W     = 2;
    localparam int ROWS_REG_W = 7;
    localparam int COLS_REG_W = 11;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [ROWS_REG_W-1:0] RESET_ROWS = ROWS_REG_W'(24);
    localparam logic [COLS_REG_W-1:0] RESET_COLS = COLS_REG_W'(80);
    localparam logic [ROW_CNT_W-1:0]  MAX_ROWS_V = ROW_CNT_W'(MAX_ROWS);
    localparam logic [COL_W-1:0]      MAX_COLS_V = COL_W'(MAX_COLS);

    localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MARK_ALL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLIP     = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_COLS = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] span_start;
        logic [COL_W-1:0] span_end;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_start;
        logic [COL_W-1:0] out_end;
        logic             span_valid;
        logic             last_span;
    } out_item_t;

    typedef struct packed {
        logic [COL_W-1:0] lo;
        logic [COL_W-1:0] hi;
    } span_t;

    typedef struct packed {
        logic [ROW_CNT_W-1:0] eff_rows;
        logic [COL_W-1:0]     eff_cols;
        logic                 load;
    } cfg_t;

    typedef struct packed {
        logic [ROW_CNT_W-1:0] band_first;
        logic [ROW_CNT_W-1:0] band_end;
        logic [MAX_ROWS-1:0]  dmg;
        logic [MAX_ROWS-1:0]  full;
    } track_status_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        span_t            data;
    } ram_wr_t;

    typedef enum logic [1:0] {
        FLIP_IDLE,
        FLIP_LOAD,
        FLIP_WALK,
        FLIP_DONE
    } flip_state_t;

    // one bit per row below the row count
    function automatic logic [MAX_ROWS-1:0] row_mask(input logic [ROW_CNT_W-1:0] nr);
        logic [MAX_ROWS-1:0] m;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            m[i] = (ROW_CNT_W'(i) < nr);
        end
        return m;
    endfunction

endpackage

// ===== rtl/rdst_ram.sv =====
// generic single write, single read memory with registered read data
// no dependencies
module rdst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rdst_cfg.sv =====
// apb register block: rows and columns in use, saturated effective values
// depends on rdst_pkg
module rdst_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdst_pkg::PADDR_W-1:0]  paddr,
    input  logic [rdst_pkg::DATA_W-1:0]   pwdata,
    output logic [rdst_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output rdst_pkg::cfg_t                cfg
);

    logic [rdst_pkg::ROWS_REG_W-1:0] rows_reg;
    logic [rdst_pkg::ROWS_REG_W-1:0] rows_next;
    logic [rdst_pkg::COLS_REG_W-1:0] cols_reg;
    logic [rdst_pkg::COLS_REG_W-1:0] cols_next;
    logic                            load_reg;
    logic                            wr;
    logic [rdst_pkg::REG_IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[2];

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr)
        begin
            case (idx)
                rdst_pkg::REG_ROWS: rows_next = pwdata[rdst_pkg::ROWS_REG_W-1:0];
                rdst_pkg::REG_COLS: cols_next = pwdata[rdst_pkg::COLS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= rdst_pkg::RESET_ROWS;
            cols_reg <= rdst_pkg::RESET_COLS;
            load_reg <= 1'b0;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            load_reg <= wr;
        end
    end

    always_comb
    begin
        case (idx)
            rdst_pkg::REG_ROWS: prdata = rdst_pkg::DATA_W'(rows_reg);
            rdst_pkg::REG_COLS: prdata = rdst_pkg::DATA_W'(cols_reg);
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.eff_rows = (rows_reg > rdst_pkg::ROWS_REG_W'(rdst_pkg::MAX_ROWS_V))
                       ? rdst_pkg::MAX_ROWS_V : rdst_pkg::ROW_CNT_W'(rows_reg);
        cfg.eff_cols = (cols_reg > rdst_pkg::MAX_COLS_V)
                       ? rdst_pkg::MAX_COLS_V : cols_reg;
        cfg.load     = load_reg;
    end

endmodule

// ===== rtl/rdst_track.sv =====
// add pipeline with read-modify-write of the span memory, damage flags and band
// depends on rdst_pkg
module rdst_track (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  rdst_pkg::in_item_t          item,
    input  rdst_pkg::cfg_t              cfg,
    input  logic                        clear,
    input  rdst_pkg::span_t             rdata,
    output logic [rdst_pkg::ROW_W-1:0]  raddr,
    output rdst_pkg::ram_wr_t           wr,
    output rdst_pkg::track_status_t     status
);

    logic                              s1_valid_reg;
    logic                              s1_valid_next;
    rdst_pkg::in_item_t                s1_item_reg;
    logic                              fwd_valid_reg;
    logic [rdst_pkg::ROW_W-1:0]        fwd_addr_reg;
    rdst_pkg::span_t                   fwd_data_reg;
    logic [rdst_pkg::MAX_ROWS-1:0]     dmg_reg;
    logic [rdst_pkg::MAX_ROWS-1:0]     dmg_next;
    logic [rdst_pkg::MAX_ROWS-1:0]     full_reg;
    logic [rdst_pkg::MAX_ROWS-1:0]     full_next;
    logic [rdst_pkg::ROW_CNT_W-1:0]    first_reg;
    logic [rdst_pkg::ROW_CNT_W-1:0]    first_next;
    logic [rdst_pkg::ROW_CNT_W-1:0]    end_reg;
    logic [rdst_pkg::ROW_CNT_W-1:0]    end_next;
    logic [rdst_pkg::MAX_ROWS-1:0]     mask;
    logic                              grid_ok;
    logic                              mark_all;
    logic                              take;
    logic [rdst_pkg::ROW_CNT_W-1:0]    row_x;
    logic [rdst_pkg::COL_W-1:0]        lo;
    logic [rdst_pkg::COL_W-1:0]        hi_c;
    rdst_pkg::span_t                   old;

    assign raddr         = item.row;
    assign s1_valid_next = accept && (item.cmd == rdst_pkg::CMD_ADD);
    assign mask          = rdst_pkg::row_mask(cfg.eff_rows);
    assign grid_ok       = (cfg.eff_rows != '0) && (cfg.eff_cols != '0);
    assign mark_all      = accept && (item.cmd == rdst_pkg::CMD_MARK_ALL) && grid_ok;

    always_comb
    begin
        row_x = rdst_pkg::ROW_CNT_W'(s1_item_reg.row);
        lo    = s1_item_reg.span_start;
        hi_c  = (s1_item_reg.span_end > cfg.eff_cols) ? cfg.eff_cols : s1_item_reg.span_end;
        take  = s1_valid_reg && (row_x < cfg.eff_rows)
                && (lo < s1_item_reg.span_end) && (lo < cfg.eff_cols);
        // the previous write is not yet visible in the registered read data
        old   = (fwd_valid_reg && (fwd_addr_reg == s1_item_reg.row)) ? fwd_data_reg : rdata;

        wr.en   = take && !full_reg[s1_item_reg.row];
        wr.addr = s1_item_reg.row;
        if (dmg_reg[s1_item_reg.row])
        begin
            wr.data.lo = (old.lo < lo) ? old.lo : lo;
            wr.data.hi = (old.hi > hi_c) ? old.hi : hi_c;
        end
        else
        begin
            wr.data.lo = lo;
            wr.data.hi = hi_c;
        end
    end

    always_comb
    begin
        dmg_next   = dmg_reg;
        full_next  = full_reg;
        first_next = first_reg;
        end_next   = end_reg;
        if (cfg.load)
        begin
            if (grid_ok)
            begin
                dmg_next   = mask;
                full_next  = mask;
                first_next = '0;
                end_next   = cfg.eff_rows;
            end
            else
            begin
                dmg_next   = '0;
                full_next  = '0;
                first_next = cfg.eff_rows;
                end_next   = '0;
            end
        end
        else if (clear)
        begin
            dmg_next   = '0;
            full_next  = '0;
            first_next = cfg.eff_rows;
            end_next   = '0;
        end
        else if (mark_all)
        begin
            dmg_next   = mask;
            full_next  = mask;
            first_next = '0;
            end_next   = cfg.eff_rows;
        end
        else if (take)
        begin
            dmg_next[s1_item_reg.row] = 1'b1;
            if (row_x < first_reg)
            begin
                first_next = row_x;
            end
            if (row_x + rdst_pkg::ROW_CNT_W'(1) > end_reg)
            begin
                end_next = row_x + rdst_pkg::ROW_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            dmg_reg       <= rdst_pkg::row_mask(rdst_pkg::ROW_CNT_W'(rdst_pkg::RESET_ROWS));
            full_reg      <= rdst_pkg::row_mask(rdst_pkg::ROW_CNT_W'(rdst_pkg::RESET_ROWS));
            first_reg     <= '0;
            end_reg       <= rdst_pkg::ROW_CNT_W'(rdst_pkg::RESET_ROWS);
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= wr.en;
            dmg_reg       <= dmg_next;
            full_reg      <= full_next;
            first_reg     <= first_next;
            end_reg       <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= item;
        fwd_addr_reg <= wr.addr;
        fwd_data_reg <= wr.data;
    end

    assign status.band_first = first_reg;
    assign status.band_end   = end_reg;
    assign status.dmg        = dmg_reg;
    assign status.full       = full_reg;

endmodule

// ===== rtl/rdst_flip.sv =====
// flip sequencer: walks the damaged band through the span memory and emits spans
// depends on rdst_pkg and row_damage_span_tracker_macros.svh
`include "row_damage_span_tracker_macros.svh"

module rdst_flip (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  rdst_pkg::track_status_t     status,
    input  rdst_pkg::cfg_t              cfg,
    input  rdst_pkg::span_t             rdata,
    output logic [rdst_pkg::ROW_W-1:0]  raddr,
    output logic                        busy,
    output logic                        clear,
    output logic                        result_valid,
    output rdst_pkg::out_item_t         result
);

    rdst_pkg::flip_state_t             state_reg;
    rdst_pkg::flip_state_t             state_next;
    logic [rdst_pkg::ROW_CNT_W-1:0]    ptr_reg;
    logic [rdst_pkg::ROW_CNT_W-1:0]    ptr_next;
    logic                              tag_valid_reg;
    logic                              tag_valid_next;
    logic [rdst_pkg::ROW_W-1:0]        tag_row_reg;
    logic [rdst_pkg::ROW_W-1:0]        tag_row_next;
    logic                              tag_dmg_reg;
    logic                              tag_dmg_next;
    logic                              tag_full_reg;
    logic                              tag_full_next;
    logic                              pend_valid_reg;
    logic                              pend_valid_next;
    logic [rdst_pkg::ROW_W-1:0]        pend_row_reg;
    logic [rdst_pkg::ROW_W-1:0]        pend_row_next;
    rdst_pkg::span_t                   pend_span_reg;
    rdst_pkg::span_t                   pend_span_next;
    logic                              result_valid_reg;
    logic                              result_valid_next;
    rdst_pkg::out_item_t               result_reg;
    rdst_pkg::out_item_t               result_next;
    rdst_pkg::span_t                   cur;

    assign raddr        = ptr_reg[rdst_pkg::ROW_W-1:0];
    assign busy         = (state_reg != rdst_pkg::FLIP_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        tag_valid_next    = 1'b0;
        tag_row_next      = tag_row_reg;
        tag_dmg_next      = tag_dmg_reg;
        tag_full_next     = tag_full_reg;
        pend_valid_next   = pend_valid_reg;
        pend_row_next     = pend_row_reg;
        pend_span_next    = pend_span_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        clear             = 1'b0;

        if (tag_full_reg)
        begin
            cur.lo = '0;
            cur.hi = cfg.eff_cols;
        end
        else
        begin
            cur = rdata;
        end

        // a span goes out once the next one is found, so the last one can be marked
        if (tag_valid_reg && tag_dmg_reg)
        begin
            if (pend_valid_reg)
            begin
                result_valid_next      = 1'b1;
                result_next.out_row    = pend_row_reg;
                result_next.out_start  = pend_span_reg.lo;
                result_next.out_end    = pend_span_reg.hi;
                result_next.span_valid = 1'b1;
                result_next.last_span  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_row_next   = tag_row_reg;
            pend_span_next  = cur;
        end

        case (state_reg)
            rdst_pkg::FLIP_IDLE:
            begin
                if (go)
                begin
                    state_next = rdst_pkg::FLIP_LOAD;
                end
            end
            rdst_pkg::FLIP_LOAD:
            begin
                ptr_next   = status.band_first;
                state_next = rdst_pkg::FLIP_WALK;
            end
            rdst_pkg::FLIP_WALK:
            begin
                if (ptr_reg < status.band_end)
                begin
                    tag_valid_next = 1'b1;
                    tag_row_next   = ptr_reg[rdst_pkg::ROW_W-1:0];
                    tag_dmg_next   = status.dmg[ptr_reg[rdst_pkg::ROW_W-1:0]];
                    tag_full_next  = status.full[ptr_reg[rdst_pkg::ROW_W-1:0]];
                    ptr_next       = ptr_reg + rdst_pkg::ROW_CNT_W'(1);
                end
                else
                begin
                    state_next = rdst_pkg::FLIP_DONE;
                end
            end
            rdst_pkg::FLIP_DONE:
            begin
                result_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next.out_row    = pend_row_reg;
                    result_next.out_start  = pend_span_reg.lo;
                    result_next.out_end    = pend_span_reg.hi;
                    result_next.span_valid = 1'b1;
                end
                else
                begin
                    result_next.out_row    = '0;
                    result_next.out_start  = '0;
                    result_next.out_end    = '0;
                    result_next.span_valid = 1'b0;
                end
                result_next.last_span = 1'b1;
                pend_valid_next       = 1'b0;
                clear                 = 1'b1;
                state_next            = rdst_pkg::FLIP_IDLE;
            end
            default:
            begin
                state_next = rdst_pkg::FLIP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rdst_pkg::FLIP_IDLE;
            tag_valid_reg    <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tag_valid_reg    <= tag_valid_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        tag_row_reg   <= tag_row_next;
        tag_dmg_reg   <= tag_dmg_next;
        tag_full_reg  <= tag_full_next;
        pend_row_reg  <= pend_row_next;
        pend_span_reg <= pend_span_next;
        result_reg    <= result_next;
    end

    `RDST_ASSERT_NEXT(a_done_emits_last, state_reg == rdst_pkg::FLIP_DONE, result_valid_reg && result_reg.last_span)
    `RDST_ASSERT_NEXT(a_done_to_idle, state_reg == rdst_pkg::FLIP_DONE, state_reg == rdst_pkg::FLIP_IDLE)
    `RDST_ASSERT_SAME(a_marker_is_last, result_valid_reg && !result_reg.span_valid, result_reg.last_span)
    `RDST_ASSERT_SAME(a_idle_nothing_held, state_reg == rdst_pkg::FLIP_IDLE, !pend_valid_reg && !tag_valid_reg)

endmodule

// ===== rtl/row_damage_span_tracker.sv =====
// top level of the row damage span tracker
// depends on rdst_pkg, rdst_cfg, rdst_ram, rdst_track and rdst_flip
//
// Commands are taken on start while busy is low. Add and mark-all are taken one per
// cycle, back to back; an add reads its row span from the span memory and writes the
// merged span in the next cycle, with the last write forwarded. A flip raises busy
// through its load, walk and done states, one span memory read per row of the damaged
// band. Each result shows on result for exactly one cycle with result_valid high and
// cannot be held off; the last one of a flip has last_span set, and a flip with no damage
// gives a single result with span_valid low. Damage state is restored at reset and after
// a register write through per-row flags, so no memory clearing pass is needed.
module row_damage_span_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  rdst_pkg::in_item_t            item,
    output logic                          result_valid,
    output rdst_pkg::out_item_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdst_pkg::PADDR_W-1:0]  paddr,
    input  logic [rdst_pkg::DATA_W-1:0]   pwdata,
    output logic [rdst_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    rdst_pkg::cfg_t                cfg;
    rdst_pkg::track_status_t       status;
    rdst_pkg::ram_wr_t             wr;
    rdst_pkg::span_t               rdata;
    logic [rdst_pkg::SPAN_W-1:0]   ram_rdata;
    logic [rdst_pkg::ROW_W-1:0]    add_raddr;
    logic [rdst_pkg::ROW_W-1:0]    walk_raddr;
    logic [rdst_pkg::ROW_W-1:0]    raddr;
    logic                          accept;
    logic                          flip_go;
    logic                          clear;

    assign accept  = start && !busy;
    assign flip_go = accept && (item.cmd == rdst_pkg::CMD_FLIP);
    assign raddr   = busy ? walk_raddr : add_raddr;
    assign rdata   = rdst_pkg::span_t'(ram_rdata);

    rdst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rdst_ram #(
        .WIDTH (rdst_pkg::SPAN_W),
        .DEPTH (rdst_pkg::MAX_ROWS)
    ) u_span_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    rdst_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg),
        .clear  (clear),
        .rdata  (rdata),
        .raddr  (add_raddr),
        .wr     (wr),
        .status (status)
    );

    rdst_flip u_flip (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (flip_go),
        .status       (status),
        .cfg          (cfg),
        .rdata        (rdata),
        .raddr        (walk_raddr),
        .busy         (busy),
        .clear        (clear),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== bench/row_damage_span_tracker_test.sv =====
// self-checking bench for row_damage_span_tracker: directed table, then random phases
// predicts every flip's span list and checks each result transfer against it
// depends on rdst_pkg and the row_damage_span_tracker rtl
module row_damage_span_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rdst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam out_item_t NOTHING_DAMAGED = '{out_row: '0, out_start: '0, out_end: '0,
                                              span_valid: 1'b0, last_span: 1'b1};

    typedef struct packed {
        logic                 is_cfg;
        logic [REG_IDX_W-1:0] reg_idx;
        logic [COL_W-1:0]     reg_val;
        in_item_t             cmd_item;
        logic                 typed;
        out_item_t            typed_res;
    } bench_step_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    in_item_t            item = '0;
    logic                result_valid;
    out_item_t           result;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [ROWS_REG_W-1:0] rows_reg;
    logic [COLS_REG_W-1:0] cols_reg;
    logic [COL_W-1:0]      row_lo [MAX_ROWS];
    logic [COL_W-1:0]      row_hi [MAX_ROWS];
    int unsigned           band_first;
    int unsigned           band_end;

    out_item_t   flip_spans [$];
    out_item_t   pending_spans [$];
    bench_step_t plan [$];
    int          phase_gap [4] = '{0, 74, 0, 20};
    int unsigned gap_pct = 0;
    int          n_errors = 0;
    int          n_cmds = 0;
    int          n_flips = 0;
    int          n_spans = 0;
    int          n_writes = 0;
    int          idle_cycles = 0;

    row_damage_span_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void flag(string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function automatic int unsigned rows_eff();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
    endfunction

    function automatic int unsigned cols_eff();
        return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
    endfunction

    function automatic void clear_damage();
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row_lo[r] = COL_W'(cols_eff());
            row_hi[r] = '0;
        end
        band_first = rows_eff();
        band_end = 0;
    endfunction

    function automatic void damage_all();
        int unsigned nr;
        int unsigned nc;
        nr = rows_eff();
        nc = cols_eff();
        if (nr == 0 || nc == 0)
            return;
        for (int unsigned r = 0; r < nr; r++)
        begin
            row_lo[r] = '0;
            row_hi[r] = COL_W'(nc);
        end
        band_first = 0;
        band_end = nr;
    endfunction

    function automatic void merge_span(logic [ROW_W-1:0] row, logic [COL_W-1:0] s,
                                       logic [COL_W-1:0] e);
        int unsigned nc;
        int unsigned lo;
        int unsigned hi;
        nc = cols_eff();
        lo = s;
        hi = e;
        if (row >= rows_eff() || lo >= hi || lo >= nc)
            return;
        if (hi > nc)
            hi = nc;
        if (row_lo[row] >= row_hi[row])
        begin
            row_lo[row] = COL_W'(lo);
            row_hi[row] = COL_W'(hi);
        end
        else
        begin
            if (lo < row_lo[row])
                row_lo[row] = COL_W'(lo);
            if (hi > row_hi[row])
                row_hi[row] = COL_W'(hi);
        end
        if (row < band_first)
            band_first = row;
        if (row + 1 > band_end)
            band_end = row + 1;
    endfunction

    // updates the tracked damage and leaves a flip's span list in flip_spans
    function automatic void track_cmd(in_item_t it);
        int unsigned last_row;
        out_item_t   sp;
        flip_spans.delete();
        case (it.cmd)
            CMD_ADD: merge_span(it.row, it.span_start, it.span_end);
            CMD_MARK_ALL: damage_all();
            CMD_FLIP:
            begin
                n_flips++;
                last_row = (band_end > MAX_ROWS) ? MAX_ROWS : band_end;
                for (int unsigned r = band_first; r < last_row; r++)
                begin
                    if (row_lo[r] < row_hi[r])
                    begin
                        sp.out_row = ROW_W'(r);
                        sp.out_start = row_lo[r];
                        sp.out_end = row_hi[r];
                        sp.span_valid = 1'b1;
                        sp.last_span = 1'b0;
                        flip_spans.push_back(sp);
                    end
                end
                if (flip_spans.size() == 0)
                    flip_spans.push_back(NOTHING_DAMAGED);
                sp = flip_spans.pop_back();
                sp.last_span = 1'b1;
                flip_spans.push_back(sp);
                clear_damage();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_span(out_item_t got);
        out_item_t want;
        n_spans++;
        if (pending_spans.size() == 0)
        begin
            flag($sformatf("unexpected result row %0d [%0d,%0d) valid %b last %b",
                           got.out_row, got.out_start, got.out_end, got.span_valid,
                           got.last_span));
            return;
        end
        want = pending_spans.pop_front();
        if (got.out_row !== want.out_row || got.out_start !== want.out_start ||
            got.out_end !== want.out_end || got.span_valid !== want.span_valid ||
            got.last_span !== want.last_span)
            flag($sformatf("expected row %0d [%0d,%0d) valid %b last %b, got row %0d [%0d,%0d) valid %b last %b",
                           want.out_row, want.out_start, want.out_end, want.span_valid,
                           want.last_span, got.out_row, got.out_start, got.out_end,
                           got.span_valid, got.last_span));
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            check_span(result);
    end

    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || result_valid === 1'b1 || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("** row_damage_span_tracker: FAILED **");
            $finish;
        end
    end

    task automatic send_cmd(input in_item_t it, input logic typed, input out_item_t typed_res);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        n_cmds++;
        track_cmd(it);
        if (typed)
            pending_spans.push_back(typed_res);
        else
            foreach (flip_spans[i])
                pending_spans.push_back(flip_spans[i]);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_spans.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write then read back, with psel held across both
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COL_W-1:0] value);
        logic [DATA_W-1:0] want;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (idx == REG_ROWS)
            rows_reg = value[ROWS_REG_W-1:0];
        else
            cols_reg = value;
        clear_damage();
        damage_all();
        n_writes++;
        want = (idx == REG_ROWS) ? DATA_W'(rows_reg) : DATA_W'(cols_reg);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== want)
            flag($sformatf("register %0d read back %0h, expected %0h", idx, prdata, want));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bench_step_t cmd_step(logic [CMD_W-1:0] c, int row, int s, int e);
        bench_step_t st;
        st = '0;
        st.cmd_item.cmd = c;
        st.cmd_item.row = ROW_W'(row);
        st.cmd_item.span_start = COL_W'(s);
        st.cmd_item.span_end = COL_W'(e);
        return st;
    endfunction

    function automatic bench_step_t typed_flip(out_item_t res);
        bench_step_t st;
        st = cmd_step(CMD_FLIP, 0, 0, 0);
        st.typed = 1'b1;
        st.typed_res = res;
        return st;
    endfunction

    function automatic bench_step_t cfg_step(logic [REG_IDX_W-1:0] idx, int value);
        bench_step_t st;
        st = '0;
        st.is_cfg = 1'b1;
        st.reg_idx = idx;
        st.reg_val = COL_W'(value);
        return st;
    endfunction

    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned nr;
        int unsigned nc;
        int unsigned lo;
        nr = rows_eff();
        nc = cols_eff();
        pick = $urandom_range(99);
        it.row = ROW_W'($urandom);
        it.span_start = COL_W'($urandom);
        it.span_end = COL_W'($urandom);
        if (pick < 70)
            it.cmd = CMD_ADD;
        else if (pick < 86)
            it.cmd = CMD_FLIP;
        else if (pick < 95)
            it.cmd = CMD_MARK_ALL;
        else
            it.cmd = CMD_UNUSED;
        if (it.cmd == CMD_ADD && nr > 0 && nc > 0 && $urandom_range(9) < 8)
        begin
            lo = $urandom_range(nc - 1);
            it.row = ROW_W'($urandom_range(nr - 1));
            it.span_start = COL_W'(lo);
            if ($urandom_range(7) == 0)
                it.span_end = '1;
            else if (lo + 1 + nc / 4 > 2047)
                it.span_end = '1;
            else
                it.span_end = COL_W'(lo + 1 + $urandom_range(nc / 4));
        end
        return it;
    endfunction

    initial
    begin
        int unsigned wr;
        int unsigned wc;
        out_item_t   one_col;

        rows_reg = RESET_ROWS;
        cols_reg = RESET_COLS;
        clear_damage();
        damage_all();
        one_col = '{out_row: '0, out_start: '0, out_end: 11'd1, span_valid: 1'b1,
                    last_span: 1'b1};

        // reset state, then rejects, merges and clamping
        plan.push_back(cmd_step(CMD_FLIP, 0, 0, 0));
        plan.push_back(typed_flip(NOTHING_DAMAGED));
        plan.push_back(cmd_step(CMD_ADD, 5, 10, 20));
        plan.push_back(cmd_step(CMD_ADD, 5, 2, 15));
        plan.push_back(cmd_step(CMD_ADD, 63, 0, 5));
        plan.push_back(cmd_step(CMD_ADD, 0, 7, 7));
        plan.push_back(cmd_step(CMD_ADD, 1, 80, 2047));
        plan.push_back(cmd_step(CMD_ADD, 2, 20, 10));
        plan.push_back(cmd_step(CMD_ADD, 23, 79, 2047));
        plan.push_back(cmd_step(CMD_UNUSED, 63, 2047, 2047));
        plan.push_back(cmd_step(CMD_FLIP, 0, 0, 0));
        // largest screen
        plan.push_back(cfg_step(REG_ROWS, MAX_ROWS));
        plan.push_back(cfg_step(REG_COLS, MAX_COLS));
        plan.push_back(cmd_step(CMD_FLIP, 63, 2047, 2047));
        plan.push_back(cmd_step(CMD_ADD, 63, 1000, 2047));
        plan.push_back(cmd_step(CMD_ADD, 0, 1023, 1024));
        plan.push_back(cmd_step(CMD_FLIP, 0, 0, 0));
        // no rows
        plan.push_back(cfg_step(REG_ROWS, 0));
        plan.push_back(typed_flip(NOTHING_DAMAGED));
        plan.push_back(cmd_step(CMD_MARK_ALL, 0, 0, 0));
        plan.push_back(cmd_step(CMD_ADD, 0, 0, 1));
        plan.push_back(typed_flip(NOTHING_DAMAGED));
        // saturated registers
        plan.push_back(cfg_step(REG_ROWS, 127));
        plan.push_back(cfg_step(REG_COLS, 2047));
        plan.push_back(cmd_step(CMD_ADD, 63, 2046, 2047));
        plan.push_back(cmd_step(CMD_ADD, 40, 1023, 2047));
        plan.push_back(cmd_step(CMD_FLIP, 0, 0, 0));
        // no columns, then the smallest screen
        plan.push_back(cfg_step(REG_COLS, 0));
        plan.push_back(typed_flip(NOTHING_DAMAGED));
        plan.push_back(cfg_step(REG_ROWS, 1));
        plan.push_back(cfg_step(REG_COLS, 1));
        plan.push_back(typed_flip(one_col));
        plan.push_back(cmd_step(CMD_ADD, 0, 0, 2047));
        plan.push_back(typed_flip(one_col));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_drained();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_cmd(plan[i].cmd_item, plan[i].typed, plan[i].typed_res);
        end

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            gap_pct = phase_gap[p];
            case ($urandom_range(4))
                0: wr = 1;
                1: wr = MAX_ROWS;
                2: wr = $urandom_range(127, MAX_ROWS + 1);
                default: wr = $urandom_range(MAX_ROWS, 1);
            endcase
            case ($urandom_range(6))
                0: wc = 1;
                1: wc = MAX_COLS;
                2: wc = $urandom_range(2047, MAX_COLS + 1);
                3: wc = 2;
                default: wc = $urandom_range(200, 2);
            endcase
            write_reg(REG_ROWS, COL_W'(wr));
            write_reg(REG_COLS, COL_W'(wc));
            repeat (55)
            begin
                if ($urandom_range(99) < 3)
                    wait_drained();
                send_cmd(random_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("ran %0d commands including %0d flips, checked %0d span results",
                 n_cmds, n_flips, n_spans);
        $display("over %0d register writes, sender gaps from 0 to 74 percent", n_writes);
        if (n_errors == 0 && pending_spans.size() == 0)
            $display("** row_damage_span_tracker: PASSED **");
        else
            $display("** row_damage_span_tracker: FAILED **");
        $finish;
    end

endmodule
